[src/hsvrgb_pkg.sv]
// Shared types and constants for the HSV to RGB pixel converter.
// Depends on nothing; every other source file refers to it by scoped names.
`timescale 1ns / 1ps

package hsvrgb_pkg;

  localparam int unsigned RAMP_W  = 17;   // Q.16 ramp value, 0..65536
  localparam int unsigned PCH_W   = 35;   // scaled channel times saturation
  localparam int unsigned PSUM_W  = 38;   // channel sum times (1 - saturation), signed

  localparam logic [RAMP_W-1:0] ONE_Q16    = 17'h10000;
  localparam logic [9:0]        ONE_Q8     = 10'd256;
  localparam logic [18:0]       SECTORS    = 19'd6;
  localparam logic [18:0]       TURN_MOD   = 19'd393216;  // six sectors of 2^16
  localparam logic [18:0]       HUE_OFFSET = 19'd65536;   // one sector of rotation
  localparam logic [7:0]        FULL_SCALE = 8'd255;

  typedef enum logic [2:0] {
    SEC_R_G_FALL = 3'd0,
    SEC_R_B_RISE = 3'd1,
    SEC_B_R_FALL = 3'd2,
    SEC_B_G_RISE = 3'd3,
    SEC_G_B_FALL = 3'd4,
    SEC_G_R_RISE = 3'd5
  } sector_t;

  typedef struct packed {
    logic [7:0]  pixel_index;
    logic [15:0] hue;
    logic [8:0]  saturation;
    logic [8:0]  brightness;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] pixel_index_out;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_out_t;

  typedef struct packed {
    logic [7:0]        pixel_index;
    logic [RAMP_W-1:0] ramp_r;
    logic [RAMP_W-1:0] ramp_g;
    logic [RAMP_W-1:0] ramp_b;
    logic [8:0]        saturation;
    logic [8:0]        brightness;
  } ramp_t;

  typedef struct packed {
    logic [7:0]               pixel_index;
    logic [PCH_W-1:0]         prod_r;
    logic [PCH_W-1:0]         prod_g;
    logic [PCH_W-1:0]         prod_b;
    logic signed [PSUM_W-1:0] prod_sum;
  } prod_t;

endpackage

[src/hsvrgb_ramp.sv]
// First pipeline stage: hue to sector and fraction, two-channel ramp, index wrap.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_ramp #(
  parameter int PIXEL_COUNT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  hsvrgb_pkg::pix_in_t up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output hsvrgb_pkg::ramp_t   dn_data
);

  logic                valid_r;
  hsvrgb_pkg::ramp_t   data_r;
  hsvrgb_pkg::ramp_t   data_nxt;
  logic                load;
  logic [18:0]         turn_raw;
  logic [18:0]         turn;
  hsvrgb_pkg::sector_t sector;
  logic [hsvrgb_pkg::RAMP_W-1:0] frac;
  logic [hsvrgb_pkg::RAMP_W-1:0] frac_inv;
  logic [7:0]          idx_wrap [256];

  // Index wrap table, folded at elaboration.
  for (genvar i = 0; i < 256; i++) begin : g_idx
    assign idx_wrap[i] = 8'(i % PIXEL_COUNT);
  end

  assign load     = !valid_r || dn_ready;
  assign up_ready = load;

  always_comb begin
    turn_raw = 19'(up_data.hue) * hsvrgb_pkg::SECTORS + hsvrgb_pkg::HUE_OFFSET;
    if (turn_raw >= hsvrgb_pkg::TURN_MOD) begin
      turn = turn_raw - hsvrgb_pkg::TURN_MOD;
    end else begin
      turn = turn_raw;
    end
    sector   = hsvrgb_pkg::sector_t'(turn[18:16]);
    frac     = {1'b0, turn[15:0]};
    frac_inv = hsvrgb_pkg::ONE_Q16 - frac;

    data_nxt.pixel_index = idx_wrap[up_data.pixel_index];
    data_nxt.saturation  = up_data.saturation;
    data_nxt.brightness  = up_data.brightness;
    data_nxt.ramp_r      = '0;
    data_nxt.ramp_g      = '0;
    data_nxt.ramp_b      = '0;
    case (sector)
      hsvrgb_pkg::SEC_R_G_FALL: begin
        data_nxt.ramp_r = hsvrgb_pkg::ONE_Q16;
        data_nxt.ramp_g = frac_inv;
      end
      hsvrgb_pkg::SEC_R_B_RISE: begin
        data_nxt.ramp_r = hsvrgb_pkg::ONE_Q16;
        data_nxt.ramp_b = frac;
      end
      hsvrgb_pkg::SEC_B_R_FALL: begin
        data_nxt.ramp_r = frac_inv;
        data_nxt.ramp_b = hsvrgb_pkg::ONE_Q16;
      end
      hsvrgb_pkg::SEC_B_G_RISE: begin
        data_nxt.ramp_b = hsvrgb_pkg::ONE_Q16;
        data_nxt.ramp_g = frac;
      end
      hsvrgb_pkg::SEC_G_B_FALL: begin
        data_nxt.ramp_b = frac_inv;
        data_nxt.ramp_g = hsvrgb_pkg::ONE_Q16;
      end
      default: begin
        data_nxt.ramp_g = hsvrgb_pkg::ONE_Q16;
        data_nxt.ramp_r = frac;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[src/hsvrgb_mult.sv]
// Stages two to four: scale ramps by value, form the channel sum, then the
// saturation products. Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_mult (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  hsvrgb_pkg::ramp_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output hsvrgb_pkg::prod_t dn_data
);

  typedef struct packed {
    logic [7:0]  pixel_index;
    logic [25:0] chan_r;
    logic [25:0] chan_g;
    logic [25:0] chan_b;
    logic [8:0]  saturation;
  } scaled_t;

  typedef struct packed {
    logic [7:0]        pixel_index;
    logic [25:0]       chan_r;
    logic [25:0]       chan_g;
    logic [25:0]       chan_b;
    logic [26:0]       chan_sum;
    logic [8:0]        saturation;
    logic signed [9:0] sat_inv;
  } summed_t;

  logic              s2_valid_r, s3_valid_r, s4_valid_r;
  scaled_t           s2_data_r, s2_data_nxt;
  summed_t           s3_data_r, s3_data_nxt;
  hsvrgb_pkg::prod_t s4_data_r, s4_data_nxt;
  logic              s2_load, s3_load, s4_load;

  assign s4_load  = !s4_valid_r || dn_ready;
  assign s3_load  = !s3_valid_r || s4_load;
  assign s2_load  = !s2_valid_r || s3_load;
  assign up_ready = s2_load;

  // Operands are widened to the product width before multiplying.
  always_comb begin
    s2_data_nxt.pixel_index = up_data.pixel_index;
    s2_data_nxt.saturation  = up_data.saturation;
    s2_data_nxt.chan_r      = 26'(up_data.ramp_r) * 26'(up_data.brightness);
    s2_data_nxt.chan_g      = 26'(up_data.ramp_g) * 26'(up_data.brightness);
    s2_data_nxt.chan_b      = 26'(up_data.ramp_b) * 26'(up_data.brightness);
  end

  always_comb begin
    s3_data_nxt.pixel_index = s2_data_r.pixel_index;
    s3_data_nxt.chan_r      = s2_data_r.chan_r;
    s3_data_nxt.chan_g      = s2_data_r.chan_g;
    s3_data_nxt.chan_b      = s2_data_r.chan_b;
    s3_data_nxt.saturation  = s2_data_r.saturation;
    s3_data_nxt.chan_sum    = 27'(s2_data_r.chan_r) + 27'(s2_data_r.chan_g)
                              + 27'(s2_data_r.chan_b);
    s3_data_nxt.sat_inv     = $signed(hsvrgb_pkg::ONE_Q8 - {1'b0, s2_data_r.saturation});
  end

  always_comb begin
    s4_data_nxt.pixel_index = s3_data_r.pixel_index;
    s4_data_nxt.prod_r = hsvrgb_pkg::PCH_W'(s3_data_r.chan_r)
                         * hsvrgb_pkg::PCH_W'(s3_data_r.saturation);
    s4_data_nxt.prod_g = hsvrgb_pkg::PCH_W'(s3_data_r.chan_g)
                         * hsvrgb_pkg::PCH_W'(s3_data_r.saturation);
    s4_data_nxt.prod_b = hsvrgb_pkg::PCH_W'(s3_data_r.chan_b)
                         * hsvrgb_pkg::PCH_W'(s3_data_r.saturation);
    s4_data_nxt.prod_sum = hsvrgb_pkg::PSUM_W'($signed({1'b0, s3_data_r.chan_sum}))
                           * hsvrgb_pkg::PSUM_W'(s3_data_r.sat_inv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (s2_load) begin
        s2_valid_r <= up_valid;
      end
      if (s3_load) begin
        s3_valid_r <= s2_valid_r;
      end
      if (s4_load) begin
        s4_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_data_r <= s2_data_nxt;
    end
    if (s3_load) begin
      s3_data_r <= s3_data_nxt;
    end
    if (s4_load) begin
      s4_data_r <= s4_data_nxt;
    end
  end

  assign dn_valid = s4_valid_r;
  assign dn_data  = s4_data_r;

endmodule

[src/hsvrgb_out.sv]
// Stages five and six: mix the products, then scale by 255/2^32 and clamp.
// Holds the output register. Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_out (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  hsvrgb_pkg::prod_t    up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output hsvrgb_pkg::pix_out_t dn_data
);

  localparam int unsigned MIX_W = 39;

  typedef struct packed {
    logic [7:0]              pixel_index;
    logic signed [MIX_W-1:0] mix_r;
    logic signed [MIX_W-1:0] mix_g;
    logic signed [MIX_W-1:0] mix_b;
  } mixed_t;

  logic                 s5_valid_r, s6_valid_r;
  mixed_t               s5_data_r, s5_data_nxt;
  hsvrgb_pkg::pix_out_t s6_data_r, s6_data_nxt;
  logic                 s5_load, s6_load;

  // Truncated x * 255 / 2^32 with negative values forced to zero and large ones to 255.
  function automatic logic [7:0] clamp_chan(input logic signed [MIX_W-1:0] mix);
    logic [MIX_W+7:0] times_255;
    logic [MIX_W-25:0] top;
    logic [7:0]       res;
    times_255 = {mix[MIX_W-1:0], 8'd0} - (MIX_W+8)'(mix[MIX_W-1:0]);
    top       = times_255[MIX_W+7:32];
    if (mix[MIX_W-1]) begin
      res = 8'd0;
    end else if (top > (MIX_W-24)'(hsvrgb_pkg::FULL_SCALE)) begin
      res = hsvrgb_pkg::FULL_SCALE;
    end else begin
      res = top[7:0];
    end
    return res;
  endfunction

  assign s6_load  = !s6_valid_r || dn_ready;
  assign s5_load  = !s5_valid_r || s6_load;
  assign up_ready = s5_load;

  always_comb begin
    s5_data_nxt.pixel_index = up_data.pixel_index;
    s5_data_nxt.mix_r = $signed({4'd0, up_data.prod_r}) + MIX_W'(up_data.prod_sum);
    s5_data_nxt.mix_g = $signed({4'd0, up_data.prod_g}) + MIX_W'(up_data.prod_sum);
    s5_data_nxt.mix_b = $signed({4'd0, up_data.prod_b}) + MIX_W'(up_data.prod_sum);
  end

  // Green and blue leave swapped: green takes the blue term and blue the green term.
  always_comb begin
    s6_data_nxt.pixel_index_out = s5_data_r.pixel_index;
    s6_data_nxt.red             = clamp_chan(s5_data_r.mix_r);
    s6_data_nxt.green           = clamp_chan(s5_data_r.mix_b);
    s6_data_nxt.blue            = clamp_chan(s5_data_r.mix_g);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
    end else begin
      if (s5_load) begin
        s5_valid_r <= up_valid;
      end
      if (s6_load) begin
        s6_valid_r <= s5_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s5_load) begin
      s5_data_r <= s5_data_nxt;
    end
    if (s6_load) begin
      s6_data_r <= s6_data_nxt;
    end
  end

  assign dn_valid = s6_valid_r;
  assign dn_data  = s6_data_r;

endmodule

[src/hsv_to_rgb_pixel_unit.sv]
// Top level of the HSV to RGB pixel converter.
// Depends on hsvrgb_pkg, hsvrgb_ramp, hsvrgb_mult and hsvrgb_out.
`timescale 1ns / 1ps

// Converts one HSV colour per transfer into an 8-bit RGB pixel for an LED
// frame buffer. The input channel (in_valid, in_ready, in_data) carries the
// pixel index, a Q0.16 hue and saturation and value in Q1.8. The result
// channel (out_valid, out_ready, out_data) carries the wrapped index and the
// red, green and blue bytes, with green and blue swapped as the LED strip
// expects.
//
// The datapath is a six-stage pipeline: sector and ramp, scale by value,
// channel sum, saturation products, mixing, and the 255 scale with clamp in
// the output register. One transfer per cycle is sustained while out_ready
// stays high; the stage-two and stage-four multipliers set the stage depth.
//
// Each stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up and a new input is still taken
// while a finished result waits on out_ready. When the receiver stalls, the
// full stages hold their contents and in_ready falls only once every stage
// is occupied. Synchronous reset clears all valid bits; the pipeline is empty
// and ready once reset is released.
module hsv_to_rgb_pixel_unit #(
  parameter int PIXEL_COUNT = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hsvrgb_pkg::pix_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hsvrgb_pkg::pix_out_t out_data
);

  logic              ramp_valid, ramp_ready;
  hsvrgb_pkg::ramp_t ramp_data;
  logic              prod_valid, prod_ready;
  hsvrgb_pkg::prod_t prod_data;

  // Stage one: sector decode, ramps and index wrap.
  hsvrgb_ramp #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_ramp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (ramp_valid),
    .dn_ready (ramp_ready),
    .dn_data  (ramp_data)
  );

  // Stages two to four: multipliers and the channel sum.
  hsvrgb_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (ramp_valid),
    .up_ready (ramp_ready),
    .up_data  (ramp_data),
    .dn_valid (prod_valid),
    .dn_ready (prod_ready),
    .dn_data  (prod_data)
  );

  // Stages five and six: mixing, scaling, clamping and the output register.
  hsvrgb_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prod_valid),
    .up_ready (prod_ready),
    .up_data  (prod_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

endmodule
